// ===== rtl/lep_pkg.sv =====
`timescale 1ns / 1ps

package lep_pkg;

   // line geometry
   localparam int LINE_MAX   = 63;
   localparam int IDX_W      = $clog2(LINE_MAX);
   localparam int POS_W      = $clog2(LINE_MAX + 1);
   localparam int MEM_DEPTH  = 2 ** IDX_W;
   localparam int OUT_POS_W  = 6;
   localparam int KIND_W     = 3;

   // command queue between parser and executor
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // result kinds
   localparam logic [KIND_W-1:0] KIND_EDIT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR = 3'd1;
   localparam logic [KIND_W-1:0] KIND_END  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EOF  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FULL = 3'd4;

   // key codes
   localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
   localparam logic [7:0] KEY_EOT       = 8'h04;
   localparam logic [7:0] KEY_DELETE    = 8'h7F;
   localparam logic [7:0] KEY_ESC       = 8'h1B;
   localparam logic [7:0] KEY_BRACKET   = 8'h5B;
   localparam logic [7:0] KEY_ONE       = 8'h31;
   localparam logic [7:0] KEY_RIGHT     = 8'h43;
   localparam logic [7:0] KEY_LEFT      = 8'h44;
   localparam logic [7:0] KEY_SPACE     = 8'h20;
   localparam logic [7:0] KEY_PRINT_LO  = 8'h20;
   localparam logic [7:0] KEY_PRINT_HI  = 8'h7E;

   typedef enum logic [3:0] {
      OP_NOP        = 4'd0,
      OP_INSERT     = 4'd1,
      OP_DELETE     = 4'd2,
      OP_RIGHT      = 4'd3,
      OP_LEFT       = 4'd4,
      OP_WORD_RIGHT = 4'd5,
      OP_WORD_LEFT  = 4'd6,
      OP_NEWLINE    = 4'd7,
      OP_EOF        = 4'd8
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
   } cmd_type;

endpackage

// ===== rtl/lep_front.sv =====
`timescale 1ns / 1ps

module lep_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_key_byte,
   input  logic             queue_full,
   output logic             cmd_push,
   output lep_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      PH_NORMAL  = 5'b00001,
      PH_ESC     = 5'b00010,
      PH_BRACKET = 5'b00100,
      PH_SKIP    = 5'b01000,
      PH_FINAL   = 5'b10000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] skip_ff, skip_in;

   assign req_ready = !queue_full;
   assign cmd_push  = req_valid && req_ready;

   always_comb begin
      phase_in = phase_ff;
      skip_in  = skip_ff;
      cmd.op   = lep_pkg::OP_NOP;
      cmd.ch   = req_key_byte;
      case (phase_ff)
         PH_NORMAL: begin
            if (req_key_byte == lep_pkg::KEY_NEWLINE) begin
               cmd.op = lep_pkg::OP_NEWLINE;
            end else if (req_key_byte == lep_pkg::KEY_EOT) begin
               cmd.op = lep_pkg::OP_EOF;
            end else if (req_key_byte == lep_pkg::KEY_DELETE) begin
               cmd.op = lep_pkg::OP_DELETE;
            end else if (req_key_byte == lep_pkg::KEY_ESC) begin
               phase_in = PH_ESC;
            end else if (req_key_byte inside
                         {[lep_pkg::KEY_PRINT_LO:lep_pkg::KEY_PRINT_HI]}) begin
               cmd.op = lep_pkg::OP_INSERT;
            end
         end
         PH_ESC: begin
            phase_in = (req_key_byte == lep_pkg::KEY_BRACKET) ? PH_BRACKET : PH_NORMAL;
         end
         PH_BRACKET: begin
            phase_in = PH_NORMAL;
            if (req_key_byte == lep_pkg::KEY_RIGHT) begin
               cmd.op = lep_pkg::OP_RIGHT;
            end else if (req_key_byte == lep_pkg::KEY_LEFT) begin
               cmd.op = lep_pkg::OP_LEFT;
            end else if (req_key_byte == lep_pkg::KEY_ONE) begin
               phase_in = PH_SKIP;
               skip_in  = 2'd2;
            end
         end
         PH_SKIP: begin
            // modifier bytes pass unchecked
            if (skip_ff != 2'd0) begin
               skip_in = skip_ff - 2'd1;
            end
            if (skip_in == 2'd0) begin
               phase_in = PH_FINAL;
            end
         end
         PH_FINAL: begin
            phase_in = PH_NORMAL;
            if (req_key_byte == lep_pkg::KEY_RIGHT) begin
               cmd.op = lep_pkg::OP_WORD_RIGHT;
            end else if (req_key_byte == lep_pkg::KEY_LEFT) begin
               cmd.op = lep_pkg::OP_WORD_LEFT;
            end
         end
         default: begin
            phase_in = PH_NORMAL;
            skip_in  = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         skip_ff  <= 2'd0;
      end else if (cmd_push) begin
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

// ===== rtl/lep_queue.sv =====
`timescale 1ns / 1ps

module lep_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lep_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output lep_pkg::cmd_type pop_cmd
);

   localparam int Depth = lep_pkg::QUEUE_DEPTH;
   localparam int PtrW  = lep_pkg::QPTR_W;
   localparam int CntW  = lep_pkg::QCNT_W;

   lep_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CntW'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/lep_back.sv =====
`timescale 1ns / 1ps

module lep_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  lep_pkg::cmd_type                 cmd,
   output logic                             cmd_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lep_pkg::KIND_W-1:0]       rsp_kind,
   output logic [7:0]                       rsp_char_out,
   output logic [lep_pkg::OUT_POS_W-1:0]    rsp_cursor_pos,
   output logic [lep_pkg::OUT_POS_W-1:0]    rsp_line_length,
   output logic                             rsp_last
);

   localparam int IdxW  = lep_pkg::IDX_W;
   localparam int PosW  = lep_pkg::POS_W;
   localparam int OutW  = lep_pkg::OUT_POS_W;
   localparam int KindW = lep_pkg::KIND_W;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b00000001,
      ST_INS     = 8'b00000010,
      ST_INS_PUT = 8'b00000100,
      ST_DEL     = 8'b00001000,
      ST_WRIGHT  = 8'b00010000,
      ST_WLEFT   = 8'b00100000,
      ST_NL      = 8'b01000000,
      ST_DONE    = 8'b10000000
   } state_type;

   logic [7:0] mem [lep_pkg::MEM_DEPTH];

   state_type        state_ff, state_in;
   logic [PosW-1:0]  cursor_ff, cursor_in;
   logic [PosW-1:0]  length_ff, length_in;
   logic [PosW-1:0]  ptr_ff, ptr_in;
   logic             seen_ff, seen_in;
   logic             first_ff, first_in;
   logic [7:0]       ch_ff, ch_in;
   logic [KindW-1:0] kind_ff, kind_in;
   logic [7:0]       rd_data_ff;
   logic [IdxW-1:0]  rd_addr;
   logic             wr_en;
   logic [IdxW-1:0]  wr_addr;
   logic [7:0]       wr_data;

   logic             rsp_valid_ff;
   logic [KindW-1:0] rsp_kind_ff;
   logic [7:0]       rsp_char_ff;
   logic [OutW-1:0]  rsp_cur_ff;
   logic [OutW-1:0]  rsp_len_ff;
   logic             rsp_last_ff;

   logic             slot_free;
   logic             out_load;
   logic [KindW-1:0] out_kind;
   logic [7:0]       out_char;
   logic [PosW-1:0]  out_cur;
   logic [PosW-1:0]  out_len;
   logic             out_last;
   logic             is_space;
   logic             in_line;
   logic             seen_eff;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign is_space  = (rd_data_ff == lep_pkg::KEY_SPACE);
   assign in_line   = (ptr_ff < length_ff);
   assign seen_eff  = seen_ff || (!first_ff && in_line && !is_space);

   always_comb begin
      state_in  = state_ff;
      cursor_in = cursor_ff;
      length_in = length_ff;
      ptr_in    = ptr_ff;
      seen_in   = seen_ff;
      first_in  = first_ff;
      ch_in     = ch_ff;
      kind_in   = kind_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff[IdxW-1:0];
      wr_data   = rd_data_ff;
      cmd_pop   = 1'b0;
      out_load  = 1'b0;
      out_kind  = lep_pkg::KIND_EDIT;
      out_char  = 8'd0;
      out_cur   = cursor_ff;
      out_len   = length_ff;
      out_last  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               kind_in  = lep_pkg::KIND_EDIT;
               ch_in    = cmd.ch;
               state_in = ST_DONE;
               case (cmd.op)
                  lep_pkg::OP_INSERT: begin
                     if (length_ff >= PosW'(lep_pkg::LINE_MAX)) begin
                        kind_in = lep_pkg::KIND_FULL;
                     end else if (cursor_ff == length_ff) begin
                        wr_en     = 1'b1;
                        wr_addr   = cursor_ff[IdxW-1:0];
                        wr_data   = cmd.ch;
                        cursor_in = cursor_ff + 1'b1;
                        length_in = length_ff + 1'b1;
                     end else begin
                        // shift the tail right, last character first
                        ptr_in   = length_ff - 1'b1;
                        state_in = ST_INS;
                     end
                  end
                  lep_pkg::OP_DELETE: begin
                     if (cursor_ff == '0) begin
                        state_in = ST_DONE;
                     end else if (cursor_ff == length_ff) begin
                        cursor_in = cursor_ff - 1'b1;
                        length_in = length_ff - 1'b1;
                     end else begin
                        ptr_in   = cursor_ff;
                        state_in = ST_DEL;
                     end
                  end
                  lep_pkg::OP_RIGHT: begin
                     if (cursor_ff < length_ff) begin
                        cursor_in = cursor_ff + 1'b1;
                     end
                  end
                  lep_pkg::OP_LEFT: begin
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_ff - 1'b1;
                     end
                  end
                  lep_pkg::OP_WORD_RIGHT: begin
                     ptr_in   = cursor_ff;
                     seen_in  = 1'b0;
                     first_in = 1'b1;
                     state_in = ST_WRIGHT;
                  end
                  lep_pkg::OP_WORD_LEFT: begin
                     ptr_in   = cursor_ff;
                     seen_in  = 1'b0;
                     state_in = ST_WLEFT;
                  end
                  lep_pkg::OP_NEWLINE: begin
                     ptr_in   = '0;
                     state_in = ST_NL;
                  end
                  lep_pkg::OP_EOF: begin
                     cursor_in = '0;
                     length_in = '0;
                     kind_in   = lep_pkg::KIND_EOF;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_INS: begin
            wr_en   = 1'b1;
            wr_addr = IdxW'(ptr_ff + 1'b1);
            if (ptr_ff == cursor_ff) begin
               state_in = ST_INS_PUT;
            end else begin
               ptr_in = ptr_ff - 1'b1;
            end
         end
         ST_INS_PUT: begin
            wr_en     = 1'b1;
            wr_addr   = cursor_ff[IdxW-1:0];
            wr_data   = ch_ff;
            cursor_in = cursor_ff + 1'b1;
            length_in = length_ff + 1'b1;
            state_in  = ST_DONE;
         end
         ST_DEL: begin
            wr_en   = 1'b1;
            wr_addr = IdxW'(ptr_ff - 1'b1);
            if (ptr_ff == length_ff - 1'b1) begin
               cursor_in = cursor_ff - 1'b1;
               length_in = length_ff - 1'b1;
               state_in  = ST_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_WRIGHT: begin
            // read data holds the character under ptr
            if (!in_line || (is_space && seen_eff)) begin
               cursor_in = ptr_ff;
               state_in  = ST_DONE;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               seen_in  = seen_eff;
               first_in = 1'b0;
            end
         end
         ST_WLEFT: begin
            // read data holds the character just before ptr
            if ((ptr_ff == '0) || (is_space && seen_ff)) begin
               cursor_in = ptr_ff;
               state_in  = ST_DONE;
            end else begin
               ptr_in  = ptr_ff - 1'b1;
               seen_in = seen_ff || !is_space;
            end
         end
         ST_NL: begin
            if (slot_free) begin
               out_load = 1'b1;
               out_cur  = '0;
               out_len  = '0;
               if (ptr_ff == length_ff) begin
                  out_kind  = lep_pkg::KIND_END;
                  cursor_in = '0;
                  length_in = '0;
                  state_in  = ST_IDLE;
               end else begin
                  out_kind = lep_pkg::KIND_CHAR;
                  out_char = rd_data_ff;
                  out_last = 1'b0;
                  ptr_in   = ptr_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               out_load = 1'b1;
               out_kind = kind_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // hold ptr steady during a stall so the read data stays put
      if (state_in == ST_WLEFT) begin
         rd_addr = IdxW'(ptr_in - 1'b1);
      end else begin
         rd_addr = ptr_in[IdxW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cursor_ff <= '0;
         length_ff <= '0;
         ptr_ff    <= '0;
         seen_ff   <= 1'b0;
         first_ff  <= 1'b0;
         kind_ff   <= lep_pkg::KIND_EDIT;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         length_ff <= length_in;
         ptr_ff    <= ptr_in;
         seen_ff   <= seen_in;
         first_ff  <= first_in;
         kind_ff   <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_char_ff <= out_char;
         rsp_cur_ff  <= OutW'(out_cur);
         rsp_len_ff  <= OutW'(out_len);
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_cursor_pos  = rsp_cur_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== rtl/line_editor_escape_parser.sv =====
`timescale 1ns / 1ps
// Each byte passes the parser and the command queue to the executor, which registers its result.
// An insert inside the line shifts the tail right before it writes the character; a delete
// shifts the tail left; word jumps walk the line a position at a time; newline sends each
// character of the line as a result, then an end result. The executor takes no new command until the last is done.
// Reset is synchronous: it clears cursor, length, parser phase, queue and output valid;
// the line memory is not cleared and needs no clearing pass.

module line_editor_escape_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_key_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lep_pkg::KIND_W-1:0]    rsp_kind,
   output logic [7:0]                    rsp_char_out,
   output logic [lep_pkg::OUT_POS_W-1:0] rsp_cursor_pos,
   output logic [lep_pkg::OUT_POS_W-1:0] rsp_line_length,
   output logic                          rsp_last
);

   logic             queue_full;
   logic             cmd_push;
   lep_pkg::cmd_type push_cmd;
   logic             cmd_pop;
   logic             cmd_valid;
   lep_pkg::cmd_type pop_cmd;

   lep_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_key_byte (req_key_byte),
      .queue_full   (queue_full),
      .cmd_push     (cmd_push),
      .cmd          (push_cmd)
   );

   lep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_cmd   (pop_cmd)
   );

   lep_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (pop_cmd),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_char_out    (rsp_char_out),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

   // only line characters leave last low
   a_last_vs_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == lep_pkg::KIND_CHAR) == !rsp_last))
      else $error("last flag does not match result kind");

   a_char_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == lep_pkg::KIND_CHAR)
         |-> (rsp_cursor_pos == '0 && rsp_line_length == '0))
      else $error("line character reports nonzero cursor or length");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != lep_pkg::KIND_CHAR) |-> (rsp_char_out == 8'd0))
      else $error("char_out nonzero outside a line character");

   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_pos <= rsp_line_length))
      else $error("cursor beyond end of line");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import lep_pkg::*;

   typedef enum logic [2:0] {
      PH_TEXT,
      PH_AFTER_ESC,
      PH_AFTER_BRACKET,
      PH_SKIP_ARGS,
      PH_JUMP_FINAL
   } esc_phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [7:0]           ch;
      logic [OUT_POS_W-1:0] pos;
      logic [OUT_POS_W-1:0] len;
      logic                 last;
   } editor_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_key_byte = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic [7:0]           rsp_char_out;
   logic [OUT_POS_W-1:0] rsp_cursor_pos;
   logic [OUT_POS_W-1:0] rsp_line_length;
   logic                 rsp_last;

   line_editor_escape_parser uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key_byte    (req_key_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_char_out    (rsp_char_out),
      .rsp_cursor_pos  (rsp_cursor_pos),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

   // predicted editor state
   logic [7:0]    line_chars [0:LINE_MAX-1];
   int            edit_cursor = 0;
   int            line_len = 0;
   esc_phase_type phase = PH_TEXT;
   int            skip_left = 0;

   editor_result_type pending_results [$];

   bit sender_pauses = 1'b1;
   bit receiver_stalls = 1'b1;
   int key_count = 0;
   int results_checked = 0;
   int mismatch_count = 0;
   int lines_emitted = 0;
   int full_drops = 0;
   int word_jumps = 0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic push_result(input logic [KIND_W-1:0] kind, input logic [7:0] ch,
                              input logic last);
      editor_result_type r;
      r.kind = kind;
      r.ch   = ch;
      r.pos  = edit_cursor[OUT_POS_W-1:0];
      r.len  = line_len[OUT_POS_W-1:0];
      r.last = last;
      pending_results.push_back(r);
   endtask

   function automatic bit space_at(input int i);
      return i < line_len && line_chars[i] == KEY_SPACE;
   endfunction

   task automatic jump_word_right;
      bit seen;
      seen = 1'b0;
      while (edit_cursor < line_len) begin
         if (space_at(edit_cursor) && seen) break;
         edit_cursor++;
         if (edit_cursor < line_len && !space_at(edit_cursor)) seen = 1'b1;
      end
   endtask

   task automatic jump_word_left;
      bit seen;
      seen = 1'b0;
      while (edit_cursor > 0) begin
         if (space_at(edit_cursor - 1) && seen) break;
         edit_cursor--;
         if (!space_at(edit_cursor)) seen = 1'b1;
      end
   endtask

   task automatic predict_key(input logic [7:0] b);
      logic [KIND_W-1:0] kind;
      int n;
      kind = KIND_EDIT;
      case (phase)
         PH_AFTER_ESC: begin
            if (b == KEY_BRACKET) phase = PH_AFTER_BRACKET;
            else phase = PH_TEXT;
         end
         PH_AFTER_BRACKET: begin
            phase = PH_TEXT;
            if (b == KEY_RIGHT) begin
               if (edit_cursor < line_len) edit_cursor++;
            end else if (b == KEY_LEFT) begin
               if (edit_cursor > 0) edit_cursor--;
            end else if (b == KEY_ONE) begin
               phase = PH_SKIP_ARGS;
               skip_left = 2;
            end
         end
         PH_SKIP_ARGS: begin
            // the two argument bytes are swallowed whatever they are
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) phase = PH_JUMP_FINAL;
         end
         PH_JUMP_FINAL: begin
            phase = PH_TEXT;
            if (b == KEY_RIGHT) begin
               jump_word_right();
               word_jumps++;
            end else if (b == KEY_LEFT) begin
               jump_word_left();
               word_jumps++;
            end
         end
         default: begin
            if (b == KEY_NEWLINE) begin
               // every result of the line reports the cleared position
               n = line_len;
               edit_cursor = 0;
               line_len = 0;
               for (int i = 0; i < n; i++) push_result(KIND_CHAR, line_chars[i], 1'b0);
               push_result(KIND_END, 8'h00, 1'b1);
               lines_emitted++;
               return;
            end else if (b == KEY_EOT) begin
               edit_cursor = 0;
               line_len = 0;
               kind = KIND_EOF;
            end else if (b == KEY_DELETE) begin
               if (edit_cursor > 0) begin
                  for (int i = edit_cursor; i < line_len; i++) line_chars[i-1] = line_chars[i];
                  edit_cursor--;
                  line_len--;
               end
            end else if (b == KEY_ESC) begin
               phase = PH_AFTER_ESC;
            end else if (b >= KEY_PRINT_LO && b <= KEY_PRINT_HI) begin
               if (line_len >= LINE_MAX) begin
                  kind = KIND_FULL;
                  full_drops++;
               end else begin
                  for (int i = line_len; i > edit_cursor; i--) line_chars[i] = line_chars[i-1];
                  line_chars[edit_cursor] = b;
                  edit_cursor++;
                  line_len++;
               end
            end
         end
      endcase
      push_result(kind, 8'h00, 1'b1);
   endtask

   task automatic send_key(input logic [7:0] b);
      if (sender_pauses && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_key_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_key(b);
      key_count++;
   endtask

   task automatic send_cursor_key(input logic [7:0] final_byte);
      send_key(KEY_ESC);
      send_key(KEY_BRACKET);
      send_key(final_byte);
   endtask

   task automatic send_word_jump(input logic [7:0] arg0, input logic [7:0] arg1,
                                 input logic [7:0] final_byte);
      send_key(KEY_ESC);
      send_key(KEY_BRACKET);
      send_key(KEY_ONE);
      send_key(arg0);
      send_key(arg1);
      send_key(final_byte);
   endtask

   function automatic logic [7:0] random_printable();
      return 8'($urandom_range(KEY_PRINT_LO, KEY_PRINT_HI));
   endfunction

   // receiver back-pressure
   always begin
      @(posedge clock);
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin : check_results
      editor_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind = rsp_kind;
         got.ch   = rsp_char_out;
         got.pos  = rsp_cursor_pos;
         got.len  = rsp_line_length;
         got.last = rsp_last;
         results_checked++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result kind %0d char %h pos %0d len %0d last %0b",
                        $realtime, got.kind, got.ch, got.pos, got.len, got.last);
         end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.ch !== want.ch || got.pos !== want.pos ||
                got.len !== want.len || got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"%0t: mismatch: expected kind %0d char %h pos %0d len %0d last %0b,",
                            " got kind %0d char %h pos %0d len %0d last %0b"}, $realtime,
                           want.kind, want.ch, want.pos, want.len, want.last,
                           got.kind, got.ch, got.pos, got.len, got.last);
            end
         end
      end
   end

   task automatic test_empty_line;
      send_key(KEY_NEWLINE);
      send_key(KEY_DELETE);
      send_cursor_key(KEY_LEFT);
   endtask

   task automatic test_directed_edits;
      send_key(KEY_SPACE);
      send_key(KEY_PRINT_HI);
      send_key("x");
      send_cursor_key(KEY_RIGHT);
      send_word_jump(";", "5", KEY_LEFT);
      send_key(KEY_ESC);
      send_key("Q");
      send_key(8'h00);
      send_key(8'hFF);
      send_key(KEY_DELETE);
      send_key(KEY_NEWLINE);
      send_key(KEY_EOT);
   endtask

   task automatic test_full_line;
      send_key(KEY_EOT);
      while (line_len < LINE_MAX) send_key(random_printable());
      send_key(random_printable());
      send_key(KEY_PRINT_LO);
      send_cursor_key(KEY_LEFT);
      send_key(random_printable());
      send_key(KEY_NEWLINE);
   endtask

   task automatic test_random_editing(input int n_keys);
      int stop_at;
      int pick;
      stop_at = key_count + n_keys;
      while (key_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            repeat ($urandom_range(1, 6)) send_key(8'($urandom_range(KEY_PRINT_LO + 1,
                                                                    KEY_PRINT_HI)));
            if ($urandom_range(0, 1)) send_key(KEY_SPACE);
         end else if (pick < 45) begin
            repeat ($urandom_range(1, 3)) send_key(KEY_DELETE);
         end else if (pick < 58) begin
            send_cursor_key($urandom_range(0, 1) ? KEY_RIGHT : KEY_LEFT);
         end else if (pick < 72) begin
            send_word_jump(8'($urandom), 8'($urandom),
                           $urandom_range(0, 1) ? KEY_RIGHT : KEY_LEFT);
         end else if (pick < 76) begin
            // history keys end the sequence without an edit
            send_cursor_key($urandom_range(0, 1) ? "A" : "B");
         end else if (pick < 82) begin
            case ($urandom_range(0, 2))
               0: begin
                  send_key(KEY_ESC);
                  send_key(8'($urandom));
               end
               1: send_cursor_key(8'($urandom));
               default: send_word_jump(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
         end else if (pick < 88) begin
            send_key(KEY_NEWLINE);
         end else if (pick < 90) begin
            send_key(KEY_EOT);
         end else begin
            send_key(8'($urandom));
         end
      end
   endtask

   task automatic wait_until_drained;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // an idle stretch catches any stray result
      repeat (100) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_line();
      test_directed_edits();
      test_random_editing(100);
      test_full_line();
      test_random_editing(90);
      sender_pauses = 1'b0;
      receiver_stalls = 1'b0;
      test_random_editing(30);
      send_key(KEY_NEWLINE);
      wait_until_drained();
      $display("Sent %0d key bytes and checked %0d results.", key_count, results_checked);
      $display("Lines emitted %0d, full-line drops %0d, word jumps %0d, mismatches %0d.",
               lines_emitted, full_drops, word_jumps, mismatch_count);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d results still outstanding", pending_results.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
